// ===== rtl/palette_rle_pixel_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the palette RLE pixel decoder
// Shared shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PALETTE_RLE_PIXEL_DECODER_MACROS_SVH
`define PALETTE_RLE_PIXEL_DECODER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/prd_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette RLE pixel decoder package
// Beat types, decoder state, register indexes and code byte field positions.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int unsigned PixCntW   = 17;
  localparam int unsigned PairCntW  = 16;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned ColorCntW = 4;
  localparam int unsigned RepeatW   = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned PalIdxW   = 3;

  // Code byte fields
  localparam int unsigned PrefixBit = 7;
  localparam int unsigned DoubleBit = 6;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgColorCount = 3'd0,
    CfgPixelCount = 3'd1,
    CfgPalette01  = 3'd2,
    CfgPalette23  = 3'd3,
    CfgPalette45  = 3'd4,
    CfgPalette67  = 3'd5
  } cfg_reg_e;

  typedef logic [3:0][CfgDataW-1:0] palette_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } code_beat_t;

  typedef struct packed {
    logic [ColorW-1:0]   first_color;
    logic [ColorW-1:0]   second_color;
    logic [PairCntW-1:0] pair_count;
    logic                second_dropped;
    logic                image_complete;
  } run_beat_t;

  typedef struct packed {
    logic               awaiting_pair;
    logic [RepeatW-1:0] pending_repeat;
    logic [PixCntW-1:0] pixels_done;
    logic               image_full;
  } dec_state_t;

  localparam dec_state_t DecStateReset = '{
    awaiting_pair:  1'b0,
    pending_repeat: '0,
    pixels_done:    '0,
    image_full:     1'b0
  };

endpackage

// ===== rtl/prd_step.sv =====
// ----------------------------------------------------------------------------
// Palette RLE pixel decoder step
// Decodes one code byte against the current image state: prefix capture,
// run length clamp, palette lookup and next state.
// ----------------------------------------------------------------------------
module prd_step
  import prd_pkg::*;
(
  input  dec_state_t               state_i,
  input  code_beat_t               beat_i,
  input  logic [ColorCntW-1:0]     color_count_i,
  input  logic [PixCntW-1:0]       total_i,
  input  palette_t                 palette_i,
  output dec_state_t               state_o,
  output logic                     res_valid_o,
  output run_beat_t                res_o
);

  logic               active;
  logic               have_pair;
  logic [PixCntW-1:0] repeat_cnt;
  logic [PixCntW-1:0] left;
  logic [PixCntW-1:0] need;
  logic [PixCntW-1:0] pairs;
  logic [PixCntW:0]   pix_run;
  logic [PixCntW:0]   done_sum;
  logic [PixCntW-1:0] done_next;
  logic               dropped;
  logic [PalIdxW-1:0] idx_a;
  logic [PalIdxW-1:0] idx_b;
  dec_state_t         st;

  // Select a palette word; even entries sit in the upper half
  function automatic logic [ColorW-1:0] pal_word(palette_t pal, logic [PalIdxW-1:0] idx);
    logic [CfgDataW-1:0] w;
    w = pal[idx[PalIdxW-1:1]];
    return idx[0] ? w[ColorW-1:0] : w[CfgDataW-1:ColorW];
  endfunction

  // Map indexes past the color count to entry 0
  function automatic logic [PalIdxW-1:0] map_idx(logic [PalIdxW-1:0] idx,
                                                 logic [ColorCntW-1:0] cnt);
    return ({1'b0, idx} < cnt) ? idx : '0;
  endfunction

  always_comb begin
    st          = state_i;
    active      = !state_i.image_full && (state_i.pixels_done < total_i);
    have_pair   = 1'b0;
    repeat_cnt  = '0;

    // Classify the byte: pair after prefix, new prefix, or single/double pair
    if (state_i.awaiting_pair) begin
      repeat_cnt = PixCntW'(state_i.pending_repeat);
      have_pair  = 1'b1;
    end else if (beat_i.code_byte[PrefixBit]) begin
      repeat_cnt = '0;
    end else begin
      repeat_cnt = beat_i.code_byte[DoubleBit] ? PixCntW'(2) : PixCntW'(1);
      have_pair  = 1'b1;
    end

    // Clamp the run to what is left of the image
    left      = total_i - state_i.pixels_done;
    need      = (left >> 1) + PixCntW'(left[0]);
    pairs     = ((repeat_cnt == '0) || (repeat_cnt > need)) ? need : repeat_cnt;
    pix_run   = {pairs, 1'b0};
    dropped   = pix_run > {1'b0, left};
    done_sum  = {1'b0, state_i.pixels_done} + pix_run;
    done_next = dropped ? total_i : done_sum[PixCntW-1:0];

    // Advance state
    if (active) begin
      if (state_i.awaiting_pair) begin
        st.awaiting_pair  = 1'b0;
        st.pending_repeat = '0;
      end else if (beat_i.code_byte[PrefixBit]) begin
        st.awaiting_pair  = 1'b1;
        st.pending_repeat = beat_i.code_byte[RepeatW-1:0];
      end
      if (have_pair) begin
        st.pixels_done = done_next;
        st.image_full  = done_next >= total_i;
      end
    end
    if (beat_i.last_byte) begin
      st = DecStateReset;
    end

    idx_a = map_idx(beat_i.code_byte[5:3], color_count_i);
    idx_b = map_idx(beat_i.code_byte[2:0], color_count_i);

    res_valid_o           = active && have_pair;
    res_o.first_color     = pal_word(palette_i, idx_a);
    res_o.second_color    = pal_word(palette_i, idx_b);
    res_o.pair_count      = pairs[PixCntW-1] ? '1 : pairs[PairCntW-1:0];
    res_o.second_dropped  = dropped;
    res_o.image_complete  = done_next >= total_i;
    state_o               = st;
  end

endmodule

// ===== rtl/palette_rle_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// Palette RLE pixel decoder
// Turns compressed icon bytes into palette-colored pixel pair runs.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | beat
//  ---------+-----------+----------------------+-------------------------
//  in       | input     | in_valid_i/in_stall_o | code byte, last flag
//  out      | output    | out_valid_o/out_stall_i| two colors, count, flags
//  cfg      | input     | cfg_valid_i/cfg_ready_o| register index, data
//
// One code byte is taken per cycle while in_stall_o is low. The run beat of a
// pair byte goes into the output register, or into the skid register when the
// output register is held, at the edge that accepts the byte. The run clamp
// and next pixel count are combinational. A skid register behind the output
// register takes one more run beat while out_stall_i is high; in_stall_o
// follows the skid register only. Reset clears state and valid flags at once.
// ----------------------------------------------------------------------------
module palette_rle_pixel_decoder
  import prd_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  code_beat_t           in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output run_beat_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  `include "palette_rle_pixel_decoder_macros.svh"

  localparam int unsigned CmpW = 25;
  localparam logic [CmpW-1:0] MaxPix = CmpW'(MAX_PIXELS);

  logic [ColorCntW-1:0] color_count_q;
  logic [PixCntW-1:0]   pixel_count_q;
  palette_t             palette_q;

  dec_state_t state_q, state_d;
  logic       res_valid;
  run_beat_t  res;
  logic [PixCntW-1:0] total;

  logic      out_vld_q, out_vld_d;
  logic      skid_vld_q, skid_vld_d;
  run_beat_t out_q, out_d;
  run_beat_t skid_q, skid_d;

  logic in_take;
  logic out_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_vld_q;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_pop     = out_vld_q && !out_stall_i;

  // Cap the pixel count at the build limit
  assign total = ({{(CmpW-PixCntW){1'b0}}, pixel_count_q} > MaxPix) ?
                 MaxPix[PixCntW-1:0] : pixel_count_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q <= ColorCntW'(8);
      pixel_count_q <= PixCntW'(256);
      palette_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgColorCount: color_count_q <= cfg_wdata_i[ColorCntW-1:0];
        CfgPixelCount: pixel_count_q <= cfg_wdata_i[PixCntW-1:0];
        CfgPalette01:  palette_q[0]  <= cfg_wdata_i;
        CfgPalette23:  palette_q[1]  <= cfg_wdata_i;
        CfgPalette45:  palette_q[2]  <= cfg_wdata_i;
        CfgPalette67:  palette_q[3]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  prd_step u_step (
    .state_i       (state_q),
    .beat_i        (in_data_i),
    .color_count_i (color_count_q),
    .total_i       (total),
    .palette_i     (palette_q),
    .state_o       (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Advance decoder state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DecStateReset;
    end else if (in_take) begin
      state_q <= state_d;
    end
  end

  // Output register and skid stage
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (out_pop) begin
      out_vld_d = 1'b0;
    end
    if (skid_vld_q && out_pop) begin
      out_vld_d  = 1'b1;
      out_d      = skid_q;
      skid_vld_d = 1'b0;
    end else if (in_take && res_valid) begin
      if (!out_vld_q || out_pop) begin
        out_vld_d = 1'b1;
        out_d     = res;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Hold payload registers without reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  `PRD_ASSERT_SAME(a_skid_behind_out, skid_vld_q, out_vld_q,
                   "skid stage holds a beat while the output register is empty")
  `PRD_ASSERT_SAME(a_pair_count_nonzero, out_vld_q, out_q.pair_count != '0,
                   "run beat with zero pair count")
  `PRD_ASSERT_NEXT(a_last_clears, in_take && in_data_i.last_byte,
                   state_q == DecStateReset,
                   "last byte did not clear the image state")

endmodule
